>>> design/mck_pkg.sv
package mck_pkg;

  // Characters on one line before the line ends by itself
  localparam int LINE_LIMIT = 128;

  localparam int CHAR_W = 8;
  localparam int DUR_W  = 8;
  localparam int REG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_DIT        = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DAH        = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SYMBOL_GAP = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LETTER_GAP = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WORD_GAP   = 3'd4;

  // ASCII codes of interest
  localparam logic [CHAR_W-1:0] ASCII_CR     = 8'd13;
  localparam logic [CHAR_W-1:0] ASCII_SPACE  = 8'd32;
  localparam logic [CHAR_W-1:0] ASCII_ZERO   = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE   = 8'd57;
  localparam logic [CHAR_W-1:0] ASCII_LOW_A  = 8'd97;
  localparam logic [CHAR_W-1:0] ASCII_LOW_Z  = 8'd122;
  // 'a' maps to table entry 10
  localparam logic [CHAR_W-1:0] LETTER_BASE  = 8'd87;

  typedef enum logic [1:0] {
    CH_IGNORE,
    CH_CR,
    CH_SPACE,
    CH_SYMBOL
  } char_kind_t;

  // Decoded character handed to the sequencer
  typedef struct packed {
    char_kind_t  kind;
    logic [7:0]  pattern;  // marker bit, then symbols, 1 = dash
    logic [2:0]  top;      // position of the marker bit
  } char_dec_t;

  // Marker-bit pattern for '0'..'9' then 'a'..'z'
  function automatic logic [7:0] code_lookup(input logic [5:0] idx);
    logic [7:0] pat;
    unique case (idx)
      6'd0:  pat = 8'h3F;  6'd1:  pat = 8'h2F;  6'd2:  pat = 8'h27;
      6'd3:  pat = 8'h23;  6'd4:  pat = 8'h21;  6'd5:  pat = 8'h20;
      6'd6:  pat = 8'h30;  6'd7:  pat = 8'h38;  6'd8:  pat = 8'h3C;
      6'd9:  pat = 8'h3E;  6'd10: pat = 8'h05;  6'd11: pat = 8'h18;
      6'd12: pat = 8'h1A;  6'd13: pat = 8'h0C;  6'd14: pat = 8'h02;
      6'd15: pat = 8'h12;  6'd16: pat = 8'h0E;  6'd17: pat = 8'h10;
      6'd18: pat = 8'h04;  6'd19: pat = 8'h17;  6'd20: pat = 8'h0D;
      6'd21: pat = 8'h14;  6'd22: pat = 8'h07;  6'd23: pat = 8'h06;
      6'd24: pat = 8'h0F;  6'd25: pat = 8'h16;  6'd26: pat = 8'h1D;
      6'd27: pat = 8'h0A;  6'd28: pat = 8'h08;  6'd29: pat = 8'h03;
      6'd30: pat = 8'h09;  6'd31: pat = 8'h11;  6'd32: pat = 8'h0B;
      6'd33: pat = 8'h19;  6'd34: pat = 8'h1B;  6'd35: pat = 8'h1C;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

>>> design/mck_decode.sv
module mck_decode (
  input  logic [mck_pkg::CHAR_W-1:0] char_code,
  output mck_pkg::char_dec_t         dec
);
  import mck_pkg::*;

  logic       is_digit;
  logic       is_letter;
  logic [7:0] idx_full;
  logic [7:0] pat;
  logic [2:0] top;

  // Classify the character
  assign is_digit  = (char_code >= ASCII_ZERO) && (char_code <= ASCII_NINE);
  assign is_letter = (char_code >= ASCII_LOW_A) && (char_code <= ASCII_LOW_Z);
  assign idx_full  = is_digit ? (char_code - ASCII_ZERO) : (char_code - LETTER_BASE);
  assign pat       = code_lookup(idx_full[5:0]);

  // Locate the marker bit (highest set bit)
  always_comb begin
    top = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (pat[i]) top = 3'(i);
    end
  end

  always_comb begin
    dec.pattern = pat;
    dec.top     = top;
    if (char_code == ASCII_CR) begin
      dec.kind = CH_CR;
    end else if (char_code == ASCII_SPACE) begin
      dec.kind = CH_SPACE;
    end else if (is_digit || is_letter) begin
      dec.kind = CH_SYMBOL;
    end else begin
      dec.kind = CH_IGNORE;
    end
  end

endmodule

>>> design/morse_character_keyer.sv
// The first segment of a character is registered on out_* after the transaction moves
// the sequencer to S_EMIT. A character is taken in S_IDLE, and a new one only after the
//   last segment of the previous one (at most ten segments) is loaded; the sequencer walks
//   one symbol or gap per cycle while the output register is free. CR and ignored characters emit nothing.
// Reset (rst_n low, synchronous): registers to 1,3,1,3,7, word start set, line count 0.
module morse_character_keyer (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [mck_pkg::REG_IDX_W-1:0]  cfg_addr,
  input  logic [7:0]                     cfg_wdata,
  // input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] char_code
  // segment stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [15:0]                    out_tdata,  // [0] key_level, [8:1] duration
  output logic                           out_tlast   // last_segment
);
  import mck_pkg::*;

  typedef enum logic {S_IDLE, S_EMIT} state_t;

  state_t           state_r;
  logic [7:0]       dit_r, dah_r, sgap_units_r, lgap_units_r, wgap_units_r;
  logic             at_word_start_r;
  logic [7:0]       line_count_r;
  logic [7:0]       pat_r;
  logic [2:0]       bit_r;
  logic             wgap_r, lgap_r, sgap_r;
  logic             out_tvalid_r;
  logic             out_level_r;
  logic [DUR_W-1:0] out_dur_r;
  logic             out_last_r;

  char_dec_t        dec;
  logic             accept;
  logic             slot_free;
  logic [8:0]       line_inc;
  logic             sym_bit;

  mck_decode u_decode (
    .char_code (in_tdata),
    .dec       (dec)
  );

  // Zero-valued register counts as one time unit
  function automatic logic [DUR_W-1:0] len_of(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign slot_free = !out_tvalid_r || out_tready;
  assign line_inc  = {1'b0, line_count_r} + 9'd1;
  // Shift unit: pick the current symbol out of the pattern
  assign sym_bit   = 1'((pat_r >> bit_r) & 8'd1);

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {7'd0, out_dur_r, out_level_r};
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      dit_r           <= 8'd1;
      dah_r           <= 8'd3;
      sgap_units_r    <= 8'd1;
      lgap_units_r    <= 8'd3;
      wgap_units_r    <= 8'd7;
      at_word_start_r <= 1'b1;
      line_count_r    <= 8'd0;
      out_tvalid_r    <= 1'b0;
      wgap_r          <= 1'b0;
      lgap_r          <= 1'b0;
      sgap_r          <= 1'b0;
    end else begin
      // Take configuration writes; drop indexes beyond the list
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_DIT:        dit_r        <= cfg_wdata;
          REG_DAH:        dah_r        <= cfg_wdata;
          REG_SYMBOL_GAP: sgap_units_r <= cfg_wdata;
          REG_LETTER_GAP: lgap_units_r <= cfg_wdata;
          REG_WORD_GAP:   wgap_units_r <= cfg_wdata;
          default: ;
        endcase
      end

      // Retire the held segment once taken; while emitting, the sequencer reloads it
      if (out_tvalid_r && out_tready && (state_r != S_EMIT)) out_tvalid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unique case (dec.kind)
              CH_CR: begin
                at_word_start_r <= 1'b1;
                line_count_r    <= 8'd0;
              end
              CH_SPACE, CH_SYMBOL: begin
                // Set up the segment run
                wgap_r  <= (dec.kind == CH_SPACE);
                lgap_r  <= (dec.kind == CH_SYMBOL) && !at_word_start_r;
                sgap_r  <= 1'b0;
                pat_r   <= dec.pattern;
                bit_r   <= dec.top - 3'd1;
                state_r <= S_EMIT;
                // Count the character; end the line at the limit
                if (line_inc >= 9'(LINE_LIMIT)) begin
                  at_word_start_r <= 1'b1;
                  line_count_r    <= 8'd0;
                end else begin
                  at_word_start_r <= (dec.kind == CH_SPACE);
                  line_count_r    <= line_inc[7:0];
                end
              end
              CH_IGNORE: ;
              default: ;
            endcase
          end
        end
        S_EMIT: begin
          // Advance one segment whenever the output register is free
          if (slot_free) begin
            out_tvalid_r <= 1'b1;
            priority if (wgap_r) begin
              out_level_r <= 1'b0;
              out_dur_r   <= len_of(wgap_units_r);
              out_last_r  <= 1'b1;
              wgap_r      <= 1'b0;
              state_r     <= S_IDLE;
            end else if (lgap_r) begin
              out_level_r <= 1'b0;
              out_dur_r   <= len_of(lgap_units_r);
              out_last_r  <= 1'b0;
              lgap_r      <= 1'b0;
            end else if (sgap_r) begin
              out_level_r <= 1'b0;
              out_dur_r   <= len_of(sgap_units_r);
              out_last_r  <= 1'b0;
              sgap_r      <= 1'b0;
            end else begin
              out_level_r <= 1'b1;
              out_dur_r   <= sym_bit ? len_of(dah_r) : len_of(dit_r);
              out_last_r  <= (bit_r == 3'd0);
              if (bit_r == 3'd0) begin
                state_r <= S_IDLE;
              end else begin
                bit_r  <= bit_r - 3'd1;
                sgap_r <= 1'b1;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
